// ===== rtl/igl_pkg.sv =====
// Shared types and constants for the interlock gate logic block.
`default_nettype none

package igl_pkg;

  localparam int NUM_COND = 12;
  localparam int COUNT_W  = $clog2(NUM_COND + 1);
  localparam int MODE_W   = 3;
  localparam int NUM_GATE = 3;
  localparam int CFG_AW   = 3;
  localparam int CFG_DW   = 12;

  typedef enum logic [MODE_W-1:0] {
    GM_NONE    = 3'd0,
    GM_AND     = 3'd1,
    GM_OR      = 3'd2,
    GM_CONNECT = 3'd3,
    GM_NOR     = 3'd4
  } gate_mode_t;

  typedef enum logic [1:0] {
    CM_NONE    = 2'd0,
    CM_AND     = 2'd1,
    CM_OR      = 2'd2,
    CM_CONNECT = 2'd3
  } comb_mode_t;

  typedef enum logic [1:0] {
    BYP_NONE      = 2'd0,
    BYP_FORCE_ON  = 2'd1,
    BYP_FORCE_OFF = 2'd2
  } byp_req_t;

  typedef enum logic [CFG_AW-1:0] {
    REG_INVERT_MASK   = 3'd0,
    REG_GATE1_MEMBERS = 3'd1,
    REG_GATE2_MEMBERS = 3'd2,
    REG_GATE3_MEMBERS = 3'd3,
    REG_BYPASS_PERMIT = 3'd4,
    REG_GATE_MODES    = 3'd5,
    REG_COMBINE_MODE  = 3'd6,
    REG_OPTION_BITS   = 3'd7
  } cfg_reg_t;

  localparam int OPT_LATCH_EN  = 0;
  localparam int OPT_FINAL_BYP = 1;

  typedef struct packed {
    logic [NUM_COND-1:0]   condition_flags;
    logic [2*NUM_COND-1:0] bypass_requests;
    logic [1:0]            final_bypass_request;
    logic                  latch_reset;
  } in_item_t;

  typedef struct packed {
    logic [NUM_COND-1:0] condition_states;
    logic [3:0]          gate_outs;
    logic                final_out;
    logic                final_out_inv;
    logic [COUNT_W-1:0]  gate1_count;
    logic [COUNT_W-1:0]  gate2_count;
    logic [COUNT_W-1:0]  gate3_count;
    logic [1:0]          combine_count;
    logic [COUNT_W-1:0]  gate1_first;
    logic [COUNT_W-1:0]  gate2_first;
    logic [COUNT_W-1:0]  gate3_first;
  } out_item_t;

  typedef struct packed {
    logic               out;
    logic [COUNT_W-1:0] count;
    logic [COUNT_W-1:0] first;
  } gate_res_t;

endpackage

`default_nettype wire

// ===== rtl/igl_gate.sv =====
// One member-mask gate: member count, first member and gate output.
`default_nettype none

module igl_gate
  import igl_pkg::*;
(
  input  wire logic [NUM_COND-1:0] values,
  input  wire logic [NUM_COND-1:0] members,
  input  wire logic [MODE_W-1:0]   mode,
  output      gate_res_t           res
);

  logic [COUNT_W-1:0] cnt;
  logic [COUNT_W-1:0] fst;
  logic               all_on;
  logic               any_on;
  logic               last_v;

  always_comb begin
    cnt    = '0;
    fst    = '0;
    last_v = 1'b0;
    for (int i = 0; i < NUM_COND; i++) begin
      cnt = cnt + COUNT_W'(members[i]);
      if (members[i]) begin
        last_v = values[i];
      end
    end
    // scan down so the lowest member wins
    for (int i = NUM_COND - 1; i >= 0; i--) begin
      if (members[i]) begin
        fst = COUNT_W'(i + 1);
      end
    end
    all_on = &(values | ~members);
    any_on = |(values & members);
  end

  always_comb begin
    res.count = cnt;
    res.first = fst;
    res.out   = 1'b0;
    if (cnt != '0) begin
      case (mode)
        GM_AND:     res.out = all_on;
        GM_OR:      res.out = any_on;
        GM_CONNECT: res.out = last_v;
        GM_NOR:     res.out = ~any_on;
        default:    res.out = 1'b0;
      endcase
    end
  end

endmodule

`default_nettype wire

// ===== rtl/interlock_gate_logic.sv =====
// Top level: config registers, input register, gate evaluation, result register, latch.
// Path: an accepted beat is held in the input register, evaluated, then captured in the result register.
// Throughput: one beat per cycle while the receiver does not stall; input and result registers decouple the two sides.
// The only feedback path is the one-bit final latch, updated as a beat moves to the result.
// Reset (synchronous, rst_n low): both stages empty, all config registers and latch zero.
`default_nettype none

module interlock_gate_logic
  import igl_pkg::*;
(
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              in_valid,
  output      logic              in_stall,
  input  wire in_item_t          in_data,
  output      logic              out_valid,
  input  wire logic              out_stall,
  output      out_item_t         out_data,
  input  wire logic              cfg_we,
  input  wire logic [CFG_AW-1:0] cfg_addr,
  input  wire logic [CFG_DW-1:0] cfg_wdata
);

  logic [NUM_COND-1:0]        invert_mask_r;
  logic [NUM_COND-1:0]        members_r [NUM_GATE];
  logic [NUM_COND-1:0]        bypass_permit_r;
  logic [NUM_GATE*MODE_W-1:0] gate_modes_r;
  logic [1:0]                 combine_mode_r;
  logic [1:0]                 option_bits_r;

  in_item_t  s1_r;
  logic      s1_valid_r;
  out_item_t out_r;
  logic      out_valid_r;
  logic      final_latch_r;
  logic      final_latch_nxt;

  logic out_free;
  logic s1_fire;
  logic in_fire;

  logic [NUM_COND-1:0] states;
  logic [NUM_COND-1:0] eff;
  gate_res_t           gres [NUM_GATE];
  logic [NUM_GATE-1:0] gval;
  logic [NUM_GATE-1:0] active;
  logic                comb;
  logic [1:0]          ccount;
  out_item_t           out_nxt;

  // config writes
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      invert_mask_r   <= '0;
      members_r[0]    <= '0;
      members_r[1]    <= '0;
      members_r[2]    <= '0;
      bypass_permit_r <= '0;
      gate_modes_r    <= '0;
      combine_mode_r  <= '0;
      option_bits_r   <= '0;
    end else if (cfg_we) begin
      unique case (cfg_reg_t'(cfg_addr))
        REG_INVERT_MASK:   invert_mask_r   <= cfg_wdata[NUM_COND-1:0];
        REG_GATE1_MEMBERS: members_r[0]    <= cfg_wdata[NUM_COND-1:0];
        REG_GATE2_MEMBERS: members_r[1]    <= cfg_wdata[NUM_COND-1:0];
        REG_GATE3_MEMBERS: members_r[2]    <= cfg_wdata[NUM_COND-1:0];
        REG_BYPASS_PERMIT: bypass_permit_r <= cfg_wdata[NUM_COND-1:0];
        REG_GATE_MODES:    gate_modes_r    <= cfg_wdata[NUM_GATE*MODE_W-1:0];
        REG_COMBINE_MODE:  combine_mode_r  <= cfg_wdata[1:0];
        REG_OPTION_BITS:   option_bits_r   <= cfg_wdata[1:0];
        default:           ;
      endcase
    end
  end

  // handshake
  assign out_free  = !out_valid_r || !out_stall;
  assign s1_fire   = s1_valid_r && out_free;
  assign in_stall  = s1_valid_r && !out_free;
  assign in_fire   = in_valid && !in_stall;
  assign out_valid = out_valid_r;
  assign out_data  = out_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (in_fire) begin
      s1_valid_r <= 1'b1;
    end else if (s1_fire) begin
      s1_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      s1_r <= in_data;
    end
  end

  // condition states and per-condition bypass
  always_comb begin
    states = s1_r.condition_flags ^ invert_mask_r;
    eff    = states;
    for (int i = 0; i < NUM_COND; i++) begin
      if (bypass_permit_r[i]) begin
        if (s1_r.bypass_requests[2*i +: 2] == BYP_FORCE_ON) begin
          eff[i] = 1'b1;
        end else if (s1_r.bypass_requests[2*i +: 2] == BYP_FORCE_OFF) begin
          eff[i] = 1'b0;
        end
      end
    end
  end

  for (genvar g = 0; g < NUM_GATE; g++) begin : g_gate
    igl_gate u_gate (
      .values  (eff),
      .members (members_r[g]),
      .mode    (gate_modes_r[g*MODE_W +: MODE_W]),
      .res     (gres[g])
    );
    assign gval[g]   = gres[g].out;
    assign active[g] = gate_modes_r[g*MODE_W +: MODE_W] != GM_NONE;
  end

  // combining gate over active gates
  always_comb begin
    ccount = '0;
    comb   = 1'b0;
    for (int i = 0; i < NUM_GATE; i++) begin
      ccount = ccount + 2'(active[i]);
    end
    case (combine_mode_r)
      CM_AND:     comb = (|active) && (&(gval | ~active));
      CM_OR:      comb = |(gval & active);
      CM_CONNECT: begin
        for (int i = 0; i < NUM_GATE; i++) begin
          if (active[i]) begin
            comb = gval[i];
          end
        end
      end
      default:    comb = 1'b0;
    endcase
    if (combine_mode_r == CM_NONE) begin
      ccount = '0;
    end
  end

  // final bypass and latch
  always_comb begin
    if (option_bits_r[OPT_FINAL_BYP] &&
        (s1_r.final_bypass_request == BYP_FORCE_ON ||
         s1_r.final_bypass_request == BYP_FORCE_OFF)) begin
      final_latch_nxt = s1_r.final_bypass_request == BYP_FORCE_ON;
    end else if (option_bits_r[OPT_LATCH_EN]) begin
      if (comb) begin
        final_latch_nxt = 1'b1;
      end else if (s1_r.latch_reset) begin
        final_latch_nxt = 1'b0;
      end else begin
        final_latch_nxt = final_latch_r;
      end
    end else begin
      final_latch_nxt = comb;
    end
  end

  always_comb begin
    out_nxt.condition_states = states;
    out_nxt.gate_outs        = {comb, gval};
    out_nxt.final_out        = final_latch_nxt;
    out_nxt.final_out_inv    = ~final_latch_nxt;
    out_nxt.gate1_count      = gres[0].count;
    out_nxt.gate2_count      = gres[1].count;
    out_nxt.gate3_count      = gres[2].count;
    out_nxt.combine_count    = ccount;
    out_nxt.gate1_first      = gres[0].first;
    out_nxt.gate2_first      = gres[1].first;
    out_nxt.gate3_first      = gres[2].first;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r   <= 1'b0;
      final_latch_r <= 1'b0;
    end else begin
      if (s1_fire) begin
        out_valid_r   <= 1'b1;
        final_latch_r <= final_latch_nxt;
      end else if (out_free) begin
        out_valid_r   <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (s1_fire) begin
      out_r <= out_nxt;
    end
  end

  a_latch_holds: assert property (@(posedge clk) disable iff (!rst_n)
    !s1_fire |=> $stable(final_latch_r))
    else $error("final latch changed without a beat");

  a_s1_holds: assert property (@(posedge clk) disable iff (!rst_n)
    (s1_valid_r && !out_free) |=> (s1_valid_r && $stable(s1_r)))
    else $error("input stage lost a stalled beat");

  a_stall_full: assert property (@(posedge clk) disable iff (!rst_n)
    in_stall |-> s1_valid_r)
    else $error("input stalled while stage empty");

  a_first_count: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> ((out_r.gate1_count == '0) == (out_r.gate1_first == '0)))
    else $error("gate one first member inconsistent with count");

  a_inv: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> (out_r.final_out_inv != out_r.final_out))
    else $error("final output and its inverse agree");

endmodule

`default_nettype wire

// ===== tb/sv/tb_top.sv =====
// Self-checking testbench for the interlock gate logic block.
`default_nettype none

module tb_top;
  import igl_pkg::*;

  localparam int RAND_PHASES = 30;
  localparam int PHASE_BEATS = 55;
  localparam int HOLD_PHASE  = 4;
  localparam int HOLD_CYCLES = 200;

  // Mode codes 5..7 are not named in the package; the block treats them as active but dead.
  localparam logic [MODE_W-1:0] GM_SPARE5 = 3'd5;
  localparam logic [MODE_W-1:0] GM_SPARE6 = 3'd6;
  localparam logic [MODE_W-1:0] GM_SPARE7 = 3'd7;
  localparam logic [1:0] BYP_CODE3 = 2'd3;

  typedef enum int {RX_FREE, RX_LIGHT, RX_HEAVY, RX_PERIODIC} rx_pattern_t;

  class interlock_tracker;
    logic [NUM_COND-1:0] invert_mask;
    logic [NUM_COND-1:0] gate_members [NUM_GATE];
    logic [NUM_COND-1:0] bypass_permit;
    logic [3*MODE_W-1:0] gate_modes;
    logic [1:0]          combine_mode;
    logic [1:0]          option_bits;
    logic                latch;
    out_item_t           pending_outputs [$];
    int unsigned         fails;

    function new();
      invert_mask   = '0;
      bypass_permit = '0;
      gate_modes    = '0;
      combine_mode  = '0;
      option_bits   = '0;
      latch         = 1'b0;
      fails         = 0;
      for (int k = 0; k < NUM_GATE; k++) gate_members[k] = '0;
    endfunction

    function void set_reg(cfg_reg_t r, logic [CFG_DW-1:0] v);
      case (r)
        REG_INVERT_MASK:   invert_mask = v;
        REG_GATE1_MEMBERS: gate_members[0] = v;
        REG_GATE2_MEMBERS: gate_members[1] = v;
        REG_GATE3_MEMBERS: gate_members[2] = v;
        REG_BYPASS_PERMIT: bypass_permit = v;
        REG_GATE_MODES:    gate_modes = v[3*MODE_W-1:0];
        REG_COMBINE_MODE:  combine_mode = v[1:0];
        REG_OPTION_BITS:   option_bits = v[1:0];
        default: ;
      endcase
    endfunction

    // Work out the result of one input beat and queue it.
    function void note_beat(in_item_t it);
      logic [NUM_COND-1:0] eff;
      logic [MODE_W-1:0]   md [NUM_GATE];
      logic [NUM_GATE-1:0] g;
      logic [COUNT_W-1:0]  cnt [NUM_GATE];
      logic [COUNT_W-1:0]  fst [NUM_GATE];
      logic                all_on, any_on, last_on, comb, seen;
      logic [1:0]          ccount, req;
      out_item_t           o;
      eff = it.condition_flags ^ invert_mask;
      o.condition_states = eff;
      for (int i = 0; i < NUM_COND; i++) begin
        req = it.bypass_requests[2*i +: 2];
        if (bypass_permit[i]) begin
          if (req == BYP_FORCE_ON) eff[i] = 1'b1;
          else if (req == BYP_FORCE_OFF) eff[i] = 1'b0;
        end
      end
      for (int k = 0; k < NUM_GATE; k++) begin
        md[k]   = gate_modes[MODE_W*k +: MODE_W];
        cnt[k]  = '0;
        fst[k]  = '0;
        all_on  = 1'b1;
        any_on  = 1'b0;
        last_on = 1'b0;
        for (int i = 0; i < NUM_COND; i++) begin
          if (gate_members[k][i]) begin
            if (cnt[k] == 0) fst[k] = COUNT_W'(i + 1);
            cnt[k]  = cnt[k] + 1'b1;
            all_on  = all_on & eff[i];
            any_on  = any_on | eff[i];
            last_on = eff[i];
          end
        end
        if (cnt[k] == 0) g[k] = 1'b0;
        else begin
          case (md[k])
            GM_AND:     g[k] = all_on;
            GM_OR:      g[k] = any_on;
            GM_CONNECT: g[k] = last_on;
            GM_NOR:     g[k] = ~any_on;
            default:    g[k] = 1'b0;
          endcase
        end
      end
      comb   = 1'b0;
      seen   = 1'b0;
      ccount = '0;
      if (combine_mode != CM_NONE) begin
        for (int k = 0; k < NUM_GATE; k++) begin
          if (md[k] != GM_NONE) begin
            case (combine_mode)
              CM_AND:  comb = seen ? (comb & g[k]) : g[k];
              CM_OR:   comb = seen ? (comb | g[k]) : g[k];
              default: comb = g[k];
            endcase
            seen   = 1'b1;
            ccount = ccount + 1'b1;
          end
        end
      end
      if (option_bits[OPT_FINAL_BYP] && (it.final_bypass_request == BYP_FORCE_ON ||
                                         it.final_bypass_request == BYP_FORCE_OFF)) begin
        latch = (it.final_bypass_request == BYP_FORCE_ON);
      end else if (option_bits[OPT_LATCH_EN]) begin
        if (comb) latch = 1'b1;
        else if (it.latch_reset) latch = 1'b0;
      end else begin
        latch = comb;
      end
      o.gate_outs     = {comb, g};
      o.final_out     = latch;
      o.final_out_inv = ~latch;
      o.gate1_count   = cnt[0];
      o.gate2_count   = cnt[1];
      o.gate3_count   = cnt[2];
      o.combine_count = ccount;
      o.gate1_first   = fst[0];
      o.gate2_first   = fst[1];
      o.gate3_first   = fst[2];
      pending_outputs.push_back(o);
    endfunction

    function void cmp_field(string name, logic [15:0] exp_v, logic [15:0] act_v);
      if (act_v !== exp_v) begin
        $error("%s: expected %0h, got %0h", name, exp_v, act_v);
        fails++;
      end
    endfunction

    function void check_beat(out_item_t got);
      out_item_t w;
      if (pending_outputs.size() == 0) begin
        $error("result beat with nothing outstanding");
        fails++;
        return;
      end
      w = pending_outputs.pop_front();
      cmp_field("condition_states", w.condition_states, got.condition_states);
      cmp_field("gate_outs", w.gate_outs, got.gate_outs);
      cmp_field("final_out", w.final_out, got.final_out);
      cmp_field("final_out_inv", w.final_out_inv, got.final_out_inv);
      cmp_field("gate1_count", w.gate1_count, got.gate1_count);
      cmp_field("gate2_count", w.gate2_count, got.gate2_count);
      cmp_field("gate3_count", w.gate3_count, got.gate3_count);
      cmp_field("combine_count", w.combine_count, got.combine_count);
      cmp_field("gate1_first", w.gate1_first, got.gate1_first);
      cmp_field("gate2_first", w.gate2_first, got.gate2_first);
      cmp_field("gate3_first", w.gate3_first, got.gate3_first);
    endfunction

    function int unsigned outstanding();
      return pending_outputs.size();
    endfunction
  endclass

  logic              clk       = 1'b0;
  logic              rst_n     = 1'b0;
  logic              in_valid  = 1'b0;
  logic              in_stall;
  in_item_t          in_data   = '0;
  logic              out_valid;
  logic              out_stall = 1'b0;
  out_item_t         out_data;
  logic              cfg_we    = 1'b0;
  logic [CFG_AW-1:0] cfg_addr  = '0;
  logic [CFG_DW-1:0] cfg_wdata = '0;

  logic long_hold_go = 1'b0;
  logic hold_done    = 1'b0;

  interlock_tracker tracker;

  interlock_gate_logic uut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data),
    .cfg_we    (cfg_we),
    .cfg_addr  (cfg_addr),
    .cfg_wdata (cfg_wdata)
  );

  always #2 clk = ~clk;

  // Check the result beat first; the input beat of the same edge belongs to a later result.
  always @(posedge clk) begin
    if (rst_n) begin
      if (out_valid && !out_stall) tracker.check_beat(out_data);
      if (in_valid && !in_stall) tracker.note_beat(in_data);
    end
  end

  task automatic write_reg(cfg_reg_t r, logic [CFG_DW-1:0] v);
    cfg_we    <= 1'b1;
    cfg_addr  <= r;
    cfg_wdata <= v;
    tracker.set_reg(r, v);
    @(posedge clk);
  endtask

  task automatic set_all(logic [NUM_COND-1:0] inv, logic [NUM_COND-1:0] g1,
                         logic [NUM_COND-1:0] g2, logic [NUM_COND-1:0] g3,
                         logic [NUM_COND-1:0] perm, logic [3*MODE_W-1:0] modes,
                         logic [1:0] comb, logic [1:0] opt);
    write_reg(REG_INVERT_MASK, inv);
    write_reg(REG_GATE1_MEMBERS, g1);
    write_reg(REG_GATE2_MEMBERS, g2);
    write_reg(REG_GATE3_MEMBERS, g3);
    write_reg(REG_BYPASS_PERMIT, perm);
    write_reg(REG_GATE_MODES, CFG_DW'(modes));
    write_reg(REG_COMBINE_MODE, CFG_DW'(comb));
    write_reg(REG_OPTION_BITS, CFG_DW'(opt));
    cfg_we <= 1'b0;
  endtask

  task automatic send_beat(in_item_t it);
    in_valid <= 1'b1;
    in_data  <= it;
    @(posedge clk);
    while (in_stall) @(posedge clk);
  endtask

  task automatic idle(int n);
    in_valid <= 1'b0;
    repeat (n) @(posedge clk);
  endtask

  // Let every outstanding result come out, then give the block a few quiet cycles.
  task automatic drain();
    in_valid <= 1'b0;
    @(posedge clk);
    while (tracker.outstanding() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  function automatic in_item_t mk(logic [NUM_COND-1:0] flags, logic [2*NUM_COND-1:0] reqs,
                                  logic [1:0] fin, logic lr);
    in_item_t it;
    it.condition_flags      = flags;
    it.bypass_requests      = reqs;
    it.final_bypass_request = fin;
    it.latch_reset          = lr;
    return it;
  endfunction

  function automatic logic [3*MODE_W-1:0] modes3(logic [MODE_W-1:0] m1, logic [MODE_W-1:0] m2,
                                                 logic [MODE_W-1:0] m3);
    return {m3, m2, m1};
  endfunction

  function automatic logic [NUM_COND-1:0] pick_mask();
    case ($urandom_range(0, 4))
      0:       return '0;
      1:       return '1;
      2:       return NUM_COND'(1) << $urandom_range(0, NUM_COND - 1);
      default: return NUM_COND'($urandom);
    endcase
  endfunction

  function automatic logic [3*MODE_W-1:0] pick_modes();
    if ($urandom_range(0, 3) == 0) return (3*MODE_W)'($urandom);
    return modes3(MODE_W'($urandom_range(0, 4)), MODE_W'($urandom_range(0, 4)),
                  MODE_W'($urandom_range(0, 4)));
  endfunction

  function automatic in_item_t rand_beat();
    in_item_t it;
    case ($urandom_range(0, 3))
      0:       it.condition_flags = NUM_COND'($urandom);
      1:       it.condition_flags = NUM_COND'($urandom & $urandom);
      2:       it.condition_flags = NUM_COND'($urandom | $urandom);
      default: it.condition_flags = $urandom_range(0, 1) ? '1 : '0;
    endcase
    it.bypass_requests      = (2*NUM_COND)'($urandom);
    it.final_bypass_request = ($urandom_range(0, 3) == 0) ? 2'($urandom_range(1, 2)) : BYP_NONE;
    it.latch_reset          = ($urandom_range(0, 3) == 0);
    return it;
  endfunction

  // Receiver: shifting stall patterns, plus one long hold to back the block up.
  initial begin : receiver
    rx_pattern_t pat;
    int          left;
    int          tick;
    pat  = RX_FREE;
    left = 0;
    tick = 0;
    @(posedge rst_n);
    forever begin
      @(posedge clk);
      tick++;
      if (long_hold_go && !hold_done) begin
        out_stall <= 1'b1;
        repeat (HOLD_CYCLES) @(posedge clk);
        hold_done = 1'b1;
      end else begin
        if (left == 0) begin
          pat  = rx_pattern_t'($urandom_range(0, 3));
          left = $urandom_range(8, 60);
        end
        left--;
        case (pat)
          RX_FREE:  out_stall <= 1'b0;
          RX_LIGHT: out_stall <= ($urandom_range(0, 3) == 0);
          RX_HEAVY: out_stall <= ($urandom_range(0, 9) < 7);
          default:  out_stall <= ((tick % 5) < 2);
        endcase
      end
    end
  end

  initial begin : stimulus
    int sent;
    int burst;
    int gap;
    tracker = new();
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;

    // Reset configuration: every gate off, combining gate off.
    set_all('0, '0, '0, '0, '0, '0, CM_NONE, 2'b00);
    send_beat(mk('0, '0, BYP_NONE, 1'b0));
    send_beat(mk('1, '1, BYP_FORCE_ON, 1'b1));
    drain();

    // AND over all, NOR with one member, CONNECT; every condition may be bypassed.
    set_all(12'hA5A, '1, 12'h001, 12'h0F0, '1, modes3(GM_AND, GM_NOR, GM_CONNECT),
            CM_AND, 2'b00);
    send_beat(mk('1, '0, BYP_NONE, 1'b0));
    send_beat(mk('0, '0, BYP_NONE, 1'b0));
    send_beat(mk(12'h5A5, '0, BYP_NONE, 1'b0));
    send_beat(mk('0, 24'h555555, BYP_NONE, 1'b0));
    send_beat(mk('0, 24'hAAAAAA, BYP_NONE, 1'b0));
    send_beat(mk('1, '1, BYP_NONE, 1'b0));
    send_beat(mk(12'h3C6, 24'h9C3A51, BYP_NONE, 1'b0));
    drain();

    // Latch and final bypass both enabled; a spare mode counts toward the combining gate.
    set_all('0, 12'h00F, '1, '1, '0, modes3(GM_OR, GM_SPARE5, GM_NONE), CM_OR, 2'b11);
    send_beat(mk(12'h001, 24'h555555, BYP_NONE, 1'b0));
    send_beat(mk('0, '0, BYP_NONE, 1'b0));
    send_beat(mk('0, '0, BYP_NONE, 1'b1));
    send_beat(mk('0, '0, BYP_FORCE_ON, 1'b0));
    send_beat(mk(12'h001, '0, BYP_FORCE_OFF, 1'b0));
    send_beat(mk(12'h001, '0, BYP_CODE3, 1'b0));
    send_beat(mk('0, '0, BYP_NONE, 1'b1));
    drain();

    // Empty gate, spare modes, CONNECT combining, final bypass without latch.
    set_all('1, 12'h800, '0, 12'hC00, 12'h0F0, modes3(GM_SPARE7, GM_AND, GM_SPARE6),
            CM_CONNECT, 2'b10);
    send_beat(mk('0, 24'h00AA55, BYP_FORCE_ON, 1'b0));
    send_beat(mk('1, '0, BYP_NONE, 1'b1));
    send_beat(mk(12'h0F0, 24'h005A00, BYP_FORCE_OFF, 1'b0));
    drain();

    // No active gate under an AND combining gate, latch enabled.
    set_all('0, '1, '1, '1, '0, modes3(GM_NONE, GM_NONE, GM_NONE), CM_AND, 2'b01);
    send_beat(mk('1, '0, BYP_NONE, 1'b0));
    send_beat(mk('0, '0, BYP_NONE, 1'b1));
    drain();

    // NOR over many members.
    set_all('0, '1, 12'hC00, 12'h003, '1, modes3(GM_NOR, GM_NOR, GM_AND), CM_AND, 2'b00);
    send_beat(mk('0, '0, BYP_NONE, 1'b0));
    send_beat(mk('1, '0, BYP_NONE, 1'b0));
    send_beat(mk('0, 24'h500005, BYP_NONE, 1'b0));
    drain();

    for (int p = 0; p < RAND_PHASES; p++) begin
      if (p == 0) set_all('0, '0, '0, '0, '0, '0, CM_NONE, 2'b00);
      else if (p == 1) set_all('1, '1, '1, '1, '1, '1, CM_CONNECT, 2'b11);
      else set_all(pick_mask(), pick_mask(), pick_mask(), pick_mask(), pick_mask(),
                   pick_modes(), 2'($urandom_range(0, 3)), 2'($urandom_range(0, 3)));
      if (p == HOLD_PHASE) long_hold_go = 1'b1;
      sent = 0;
      while (sent < PHASE_BEATS) begin
        burst = $urandom_range(1, 16);
        gap   = (p == HOLD_PHASE || $urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
        for (int b = 0; b < burst && sent < PHASE_BEATS; b++) begin
          send_beat(rand_beat());
          sent++;
        end
        if (gap > 0) idle(gap);
      end
      drain();
    end

    repeat (8) @(posedge clk);
    if (tracker.outstanding() != 0) begin
      $error("%0d expected results never arrived", tracker.outstanding());
      tracker.fails++;
    end
    if (tracker.fails == 0) $display("tb_top: PASS");
    else $display("tb_top: FAIL");
    $finish;
  end

  initial begin : watchdog
    #2000000;
    $display("tb_top: FAIL");
    $finish;
  end

endmodule

`default_nettype wire

// ===== filelist.f =====
rtl/igl_pkg.sv
rtl/igl_gate.sv
rtl/interlock_gate_logic.sv
tb/sv/tb_top.sv
